// ----- hw/rtl/radial_velocity_scaler_macros.svh -----
// assertion macros used by the radial velocity scaler rtl
`ifndef RADIAL_VELOCITY_SCALER_MACROS_SVH
`define RADIAL_VELOCITY_SCALER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RVS_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/rvs_pkg.sv -----
// types and constants of the radial velocity scaler
package rvs_pkg;

	localparam int unsigned RAD_W    = 23;
	localparam int unsigned AMT_W    = 21;
	localparam int unsigned DSQ_W    = 2 * RAD_W;
	localparam int unsigned ROOT_W   = RAD_W;
	localparam int unsigned RATIO_W  = 17;
	localparam int unsigned FACTOR_W = 21;
	localparam int unsigned SQRT_LAT = ROOT_W;
	localparam int unsigned DIV_LAT  = RATIO_W;

	localparam logic [RAD_W-1:0]    RADIUS_MIN = RAD_W'(16384);
	localparam logic [RAD_W-1:0]    RADIUS_MAX = RAD_W'(6553600);
	localparam logic [AMT_W-1:0]    AMOUNT_MAX = AMT_W'(1048576);
	localparam logic [RATIO_W-1:0]  ONE_Q16    = RATIO_W'(65536);

	typedef enum logic [2:0] {
		CFG_CENTER_X    = 3'd0,
		CFG_CENTER_Y    = 3'd1,
		CFG_CENTER_Z    = 3'd2,
		CFG_RADIUS      = 3'd3,
		CFG_AMOUNT      = 3'd4,
		CFG_HEAT_MODE   = 3'd5,
		CFG_PLANAR_MODE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} pcl_t;

	typedef struct packed {
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic               inside_brush;
	} res_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} side_t;

	// magnitude of the difference of two signed words, exact in 33 bits
	function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [33:0] d;
		d = {a[31], a[31], a} - {b[31], b[31], b};
		return d[33] ? 33'(-d) : 33'(d);
	endfunction

endpackage

// ----- hw/rtl/rvs_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module rvs_isqrt import rvs_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DSQ_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root
);

	localparam int unsigned REM_W = ROOT_W + 4;

	logic [REM_W-1:0]  rem_s  [0:SQRT_LAT-1];
	logic [ROOT_W-1:0] root_s [0:SQRT_LAT-1];
	logic [DSQ_W-1:0]  n_s    [0:SQRT_LAT-1];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [DSQ_W-1:0]  n_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign n_in    = radicand;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign n_in    = n_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_sh = {rem_in[REM_W-3:0], n_in[DSQ_W-1 -: 2]};
		assign trial  = REM_W'({root_in, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				n_s[k]    <= {n_in[DSQ_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQRT_LAT-1];

endmodule

// ----- hw/rtl/rvs_div.sv -----
// pipelined restoring divider for dist * 65536 / radius with dist <= radius
module rvs_div import rvs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [ROOT_W-1:0]  distance,
	input  logic [RAD_W-1:0]   radius,
	output logic [RATIO_W-1:0] ratio
);

	logic [RAD_W-1:0]   rem_s [0:DIV_LAT-1];
	logic [RATIO_W-1:0] q_s   [0:DIV_LAT-1];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [RAD_W:0]     r_sh;
		logic [RATIO_W-1:0] q_in;
		logic               ge;

		if (k == 0) begin : g_first
			assign r_sh = {1'b0, distance};
			assign q_in = '0;
		end else begin : g_next
			assign r_sh = {rem_s[k-1], 1'b0};
			assign q_in = q_s[k-1];
		end

		assign ge = r_sh >= {1'b0, radius};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RAD_W'(r_sh - {1'b0, radius}) : RAD_W'(r_sh);
				q_s[k]   <= {q_in[RATIO_W-2:0], ge};
			end
		end
	end

	assign ratio = q_s[DIV_LAT-1];

endmodule

// ----- hw/rtl/radial_velocity_scaler.sv -----
// an accepted particle passes stages 1 to 3, the root and divider stages, t1 to t3 and the output register
// throughput: one particle per cycle while the result side does not stall; the whole pipeline advances together
// a stall on the result side holds every stage, the input is ready when the output frees
// the root unit takes 23 stages and the divider 17, which set the latency
// reset clears valid bits and loads the register defaults; no clearing pass
module radial_velocity_scaler import rvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pcl_valid,
	output logic        pcl_ready,
	input  pcl_t        pcl,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

`include "radial_velocity_scaler_macros.svh"

	localparam int unsigned DLY_D = SQRT_LAT + DIV_LAT;

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [RAD_W-1:0]   radius_q;
	logic [AMT_W-1:0]   amount_q;
	logic               heat_mode_q, planar_mode_q;
	logic [DSQ_W-1:0]   rad_sq_q;

	logic [RAD_W-1:0]   rad_cl;
	logic [AMT_W-1:0]   amt_cl;
	logic               adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
			radius_q      <= RAD_W'(65536);
			amount_q      <= '0;
			heat_mode_q   <= 1'b1;
			planar_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:    center_x_q    <= cfg_wdata;
				CFG_CENTER_Y:    center_y_q    <= cfg_wdata;
				CFG_CENTER_Z:    center_z_q    <= cfg_wdata;
				CFG_RADIUS:      radius_q      <= cfg_wdata[RAD_W-1:0];
				CFG_AMOUNT:      amount_q      <= cfg_wdata[AMT_W-1:0];
				CFG_HEAT_MODE:   heat_mode_q   <= cfg_wdata[0];
				CFG_PLANAR_MODE: planar_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign rad_cl = (radius_q < RADIUS_MIN) ? RADIUS_MIN :
		(radius_q > RADIUS_MAX) ? RADIUS_MAX : radius_q;
	assign amt_cl = (amount_q > AMOUNT_MAX) ? AMOUNT_MAX : amount_q;

	// settles long before any particle if the user changes config only when idle; the block does not enforce that
	always_ff @(posedge clk) begin
		rad_sq_q <= rad_cl * rad_cl;
	end

	assign adv       = !res_valid || res_ready;
	assign pcl_ready = adv;

	// stage 1: offsets from the centre and the per-axis box test
	logic [32:0]        ax, ay, az;
	logic               valid_s1, near_s1;
	logic [RAD_W-1:0]   ax_s1, ay_s1, az_s1;
	logic signed [31:0] vx_s1, vy_s1, vz_s1;

	assign ax = abs_diff(pcl.pos_x, center_x_q);
	assign ay = abs_diff(pcl.pos_y, center_y_q);
	assign az = planar_mode_q ? '0 : abs_diff(pcl.pos_z, center_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pcl_valid && pcl_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s1 <= (ax <= 33'(rad_cl)) && (ay <= 33'(rad_cl)) && (az <= 33'(rad_cl));
			ax_s1   <= ax[RAD_W-1:0];
			ay_s1   <= ay[RAD_W-1:0];
			az_s1   <= az[RAD_W-1:0];
			vx_s1   <= pcl.vel_x;
			vy_s1   <= pcl.vel_y;
			vz_s1   <= pcl.vel_z;
		end
	end

	// stage 2: squares
	logic               valid_s2, near_s2;
	logic [DSQ_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic signed [31:0] vx_s2, vy_s2, vz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s2 <= near_s1;
			sx_s2   <= ax_s1 * ax_s1;
			sy_s2   <= ay_s1 * ay_s1;
			sz_s2   <= az_s1 * az_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			vz_s2   <= vz_s1;
		end
	end

	// stage 3: squared distance against the squared radius, gated by a nonzero amount
	logic [DSQ_W+1:0]   dsq;
	logic               valid_s3, inside_s3;
	logic [DSQ_W-1:0]   dsq_s3;
	logic signed [31:0] vx_s3, vy_s3, vz_s3;

	assign dsq = (DSQ_W+2)'(sx_s2) + (DSQ_W+2)'(sy_s2) + (DSQ_W+2)'(sz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s3 <= near_s2 && (dsq <= (DSQ_W+2)'(rad_sq_q)) && (amt_cl != '0);
			dsq_s3    <= dsq[DSQ_W-1:0];
			vx_s3     <= vx_s2;
			vy_s3     <= vy_s2;
			vz_s3     <= vz_s2;
		end
	end

	// side data runs beside the root and divider stages
	side_t            dly_s [0:DLY_D-1];
	logic [DLY_D-1:0] dly_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_s <= '0;
		end else if (adv) begin
			dly_vld_s <= {dly_vld_s[DLY_D-2:0], valid_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_s[0].hit   <= inside_s3;
			dly_s[0].vel_x <= vx_s3;
			dly_s[0].vel_y <= vy_s3;
			dly_s[0].vel_z <= vz_s3;
			for (int i = 1; i < DLY_D; i++) begin
				dly_s[i].hit   <= dly_s[i-1].hit;
				dly_s[i].vel_x <= dly_s[i-1].vel_x;
				dly_s[i].vel_y <= dly_s[i-1].vel_y;
				dly_s[i].vel_z <= dly_s[i-1].vel_z;
			end
		end
	end

	logic [ROOT_W-1:0]  distance;
	logic [RATIO_W-1:0] ratio;

	rvs_isqrt u_isqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (dsq_s3),
		.root     (distance)
	);

	rvs_div u_div (
		.clk      (clk),
		.en       (adv),
		.distance (distance),
		.radius   (rad_cl),
		.ratio    (ratio)
	);

	// t1: falloff times amount
	logic [RATIO_W-1:0]       falloff;
	logic                     valid_t1, inside_t1;
	logic [AMT_W+RATIO_W-1:0] term_t1;
	logic signed [31:0]       vx_t1, vy_t1, vz_t1;

	assign falloff = (ratio > ONE_Q16) ? '0 : ONE_Q16 - ratio;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_t1 <= 1'b0;
		end else if (adv) begin
			valid_t1 <= dly_vld_s[DLY_D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_t1 <= dly_s[DLY_D-1].hit;
			term_t1   <= amt_cl * falloff;
			vx_t1     <= dly_s[DLY_D-1].vel_x;
			vy_t1     <= dly_s[DLY_D-1].vel_y;
			vz_t1     <= dly_s[DLY_D-1].vel_z;
		end
	end

	// t2: scale factor and velocity magnitudes
	logic [FACTOR_W-1:0] term;
	logic                valid_t2, inside_t2;
	logic [FACTOR_W-1:0] factor_t2;
	logic [31:0]         mx_t2, my_t2, mz_t2;
	logic signed [31:0]  vx_t2, vy_t2, vz_t2;

	assign term = term_t1[16 +: FACTOR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_t2 <= 1'b0;
		end else if (adv) begin
			valid_t2 <= valid_t1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_t2 <= inside_t1;
			if (heat_mode_q) begin
				factor_t2 <= FACTOR_W'(ONE_Q16) + term;
			end else begin
				factor_t2 <= (term >= FACTOR_W'(ONE_Q16)) ? '0 : FACTOR_W'(ONE_Q16) - term;
			end
			mx_t2 <= vx_t1[31] ? 32'(-vx_t1) : 32'(vx_t1);
			my_t2 <= vy_t1[31] ? 32'(-vy_t1) : 32'(vy_t1);
			mz_t2 <= vz_t1[31] ? 32'(-vz_t1) : 32'(vz_t1);
			vx_t2 <= vx_t1;
			vy_t2 <= vy_t1;
			vz_t2 <= vz_t1;
		end
	end

	// t3: magnitude products
	logic                   valid_t3, inside_t3;
	logic [32+FACTOR_W-1:0] px_t3, py_t3, pz_t3;
	logic signed [31:0]     vx_t3, vy_t3, vz_t3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_t3 <= 1'b0;
		end else if (adv) begin
			valid_t3 <= valid_t2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_t3 <= inside_t2;
			px_t3     <= mx_t2 * factor_t2;
			py_t3     <= my_t2 * factor_t2;
			pz_t3     <= mz_t2 * factor_t2;
			vx_t3     <= vx_t2;
			vy_t3     <= vy_t2;
			vz_t3     <= vz_t2;
		end
	end

	// saturate the magnitude and put the sign back
	function automatic logic [31:0] sat_vel(input logic neg,
			input logic [32+FACTOR_W-1:0] prod);
		logic [FACTOR_W+15:0] mag;
		mag = prod[32+FACTOR_W-1:16];
		if (neg) begin
			return (mag > (FACTOR_W+16)'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-mag);
		end
		return (mag > (FACTOR_W+16)'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[31:0];
	endfunction

	res_t res_q;
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_t3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.inside_brush <= inside_t3;
			if (inside_t3) begin
				res_q.new_vel_x <= sat_vel(vx_t3[31], px_t3);
				res_q.new_vel_y <= sat_vel(vy_t3[31], py_t3);
				res_q.new_vel_z <= sat_vel(vz_t3[31], pz_t3);
			end else begin
				res_q.new_vel_x <= vx_t3;
				res_q.new_vel_y <= vy_t3;
				res_q.new_vel_z <= vz_t3;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`RVS_ASSERT_HOLDS(a_zero_amount_outside, res_valid_q && (amt_cl == '0), !res_q.inside_brush, "inside flagged with zero amount")
	`RVS_ASSERT_HOLDS(a_root_in_radius, dly_vld_s[SQRT_LAT-1] && dly_s[SQRT_LAT-1].hit, distance <= rad_cl, "root exceeds radius")
	`RVS_ASSERT_HOLDS(a_ratio_bound, dly_vld_s[DLY_D-1] && dly_s[DLY_D-1].hit, ratio <= ONE_Q16, "ratio above one")
	`RVS_ASSERT_NEXT(a_stall_holds, !adv, $stable(valid_t3) && $stable(factor_t2), "pipeline moved during stall")

endmodule

// ----- test/tb_radial_velocity_scaler.sv -----
// testbench of the radial velocity scaler: directed table, then random particles under a brush
module tb_radial_velocity_scaler;
	import rvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 47;
	localparam int N_RANDOM = 1530;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pcl_valid = 1'b0;
	logic pcl_ready;
	pcl_t pcl = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	radial_velocity_scaler dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// brush settings as the scaler should hold them
	logic [31:0] br_cx, br_cy, br_cz;
	logic [22:0] br_radius;
	logic [20:0] br_amount;
	logic br_heat, br_planar;

	res_t scaled_q[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 0;

	typedef struct {
		pcl_t p;
		bit known;
		res_t r;
	} row_t;
	row_t rows[$];

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] scale_word(input logic signed [31:0] v, input logic [63:0] f);
		logic [63:0] mag;
		mag = v < 0 ? 64'(-64'(v)) : 64'(v);
		mag = (mag * f) >> 16;
		if (v < 0) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			return 32'(-mag);
		end
		if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic logic [32:0] offset(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [33:0] d;
		d = 34'(a) - 34'(b);
		return d < 0 ? 33'(-d) : 33'(d);
	endfunction

	function automatic res_t brush_velocity(input pcl_t p);
		res_t r;
		logic [63:0] rad, amt, ax, ay, az, dsq, ratio, term, f;
		rad = br_radius;
		amt = br_amount;
		if (rad < RADIUS_MIN) rad = RADIUS_MIN;
		if (rad > RADIUS_MAX) rad = RADIUS_MAX;
		if (amt > AMOUNT_MAX) amt = AMOUNT_MAX;
		r.new_vel_x = p.vel_x;
		r.new_vel_y = p.vel_y;
		r.new_vel_z = p.vel_z;
		r.inside_brush = 1'b0;
		if (amt == 0) return r;
		ax = offset(p.pos_x, br_cx);
		ay = offset(p.pos_y, br_cy);
		az = br_planar ? 0 : offset(p.pos_z, br_cz);
		if (ax > rad || ay > rad || az > rad) return r;
		dsq = ax * ax + ay * ay + az * az;
		if (dsq > rad * rad) return r;
		ratio = (root64(dsq) << 16) / rad;
		if (ratio > 65536) ratio = 65536;
		term = (amt * (65536 - ratio)) >> 16;
		if (br_heat) f = 65536 + term;
		else f = term >= 65536 ? 0 : 65536 - term;
		r.new_vel_x = scale_word(p.vel_x, f);
		r.new_vel_y = scale_word(p.vel_y, f);
		r.new_vel_z = scale_word(p.vel_z, f);
		r.inside_brush = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// result side: random stalls unless quiet, checks every transfer
	always @(posedge clk) begin
		res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (scaled_q.size() == 0) begin
					report("unexpected result", res.new_vel_x, 0);
				end else begin
					e = scaled_q.pop_front();
					if (res.new_vel_x !== e.new_vel_x) report("new_vel_x", res.new_vel_x, e.new_vel_x);
					if (res.new_vel_y !== e.new_vel_y) report("new_vel_y", res.new_vel_y, e.new_vel_y);
					if (res.new_vel_z !== e.new_vel_z) report("new_vel_z", res.new_vel_z, e.new_vel_z);
					if (res.inside_brush !== e.inside_brush)
						report("inside_brush", res.inside_brush, e.inside_brush);
				end
			end
			res_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CENTER_X:    br_cx = val;
			CFG_CENTER_Y:    br_cy = val;
			CFG_CENTER_Z:    br_cz = val;
			CFG_RADIUS:      br_radius = val[22:0];
			CFG_AMOUNT:      br_amount = val[20:0];
			CFG_HEAT_MODE:   br_heat = val[0];
			CFG_PLANAR_MODE: br_planar = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		pcl_valid <= 1'b0;
		while (scaled_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// offers one particle, idles first at random, holds until the transfer
	task automatic send(input pcl_t p, input bit known, input res_t r);
		if (!quiet && $urandom_range(99) < 23) begin
			pcl_valid <= 1'b0;
			@(posedge clk);
			while (!quiet && $urandom_range(99) < 23) @(posedge clk);
		end
		pcl_valid <= 1'b1;
		pcl <= p;
		scaled_q.push_back(known ? r : brush_velocity(p));
		@(posedge clk);
		while (!pcl_ready) @(posedge clk);
	endtask

	function automatic logic [31:0] near(input logic [31:0] c, input logic [22:0] rad);
		int span;
		span = $urandom_range(3) == 0 ? int'(rad) * 2 : int'(rad);
		return c + 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic pcl_t rand_pcl();
		pcl_t p;
		p.vel_x = $urandom;
		p.vel_y = $urandom;
		p.vel_z = $urandom;
		if ($urandom_range(9) < 8) begin
			p.pos_x = near(br_cx, br_radius);
			p.pos_y = near(br_cy, br_radius);
			p.pos_z = near(br_cz, br_radius);
		end else begin
			p.pos_x = $urandom;
			p.pos_y = $urandom;
			p.pos_z = $urandom;
		end
		return p;
	endfunction

	function automatic row_t mk(input logic [31:0] px, py, pz, vx, vy, vz, input bit known,
			input logic [31:0] ex, ey, ez, input bit ein);
		row_t w;
		w.p = '{px, py, pz, vx, vy, vz};
		w.known = known;
		w.r = '{ex, ey, ez, ein};
		return w;
	endfunction

	initial begin
		res_t none;
		none = '0;
		br_cx = 0; br_cy = 0; br_cz = 0;
		br_radius = 23'd65536; br_amount = 0; br_heat = 1; br_planar = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero amount after reset: everything passes
		rows.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0));
		rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'h10000, 1,
			32'hFFFF_FFFF, 0, 32'h10000, 0));
		foreach (rows[i]) send(rows[i].p, rows[i].known, rows[i].r);
		drain();
		rows.delete();

		// heat at full amount: centre gives factor 17, rim gives 1, outside passes
		write_reg(CFG_AMOUNT, 32'd1048576);
		rows.push_back(mk(0, 0, 0, 32'h10000, 32'hFFFF_0000, 0, 1,
			32'h110000, 32'hFFEF_0000, 0, 1));
		rows.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h11, 1));
		rows.push_back(mk(32'h10000, 0, 0, 32'h1234, 32'h5678, 32'h9ABC, 1,
			32'h1234, 32'h5678, 32'h9ABC, 1));
		rows.push_back(mk(32'h10001, 0, 0, 32'h1234, 32'h5678, 32'h9ABC, 1,
			32'h1234, 32'h5678, 32'h9ABC, 0));
		rows.push_back(mk(32'h8000, 32'h8000, 32'h8000, 32'h1234, 32'hFFFF_8000, 5, 0, 0, 0, 0, 0));
		rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2, 3, 1, 1, 2, 3, 0));
		foreach (rows[i]) send(rows[i].p, rows[i].known, rows[i].r);
		drain();
		rows.delete();

		// cool, amount above range saturates, radius below range clamps
		write_reg(CFG_HEAT_MODE, 0);
		write_reg(CFG_AMOUNT, 32'h1F_FFFF);
		write_reg(CFG_RADIUS, 32'd1);
		rows.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1, 0, 0, 0, 1));
		rows.push_back(mk(32'h4000, 0, 0, 32'h10000, 1, 2, 1, 32'h10000, 1, 2, 1));
		rows.push_back(mk(32'h2000, 32'h1000, 0, 32'h10000, 32'hFFFF_0000, 7, 0, 0, 0, 0, 0));
		foreach (rows[i]) send(rows[i].p, rows[i].known, rows[i].r);
		drain();
		rows.delete();

		// planar with extreme centres and radius above range
		write_reg(CFG_PLANAR_MODE, 1);
		write_reg(CFG_RADIUS, 32'h7F_FFFF);
		write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(CFG_CENTER_Y, 32'h8000_0000);
		write_reg(CFG_CENTER_Z, 32'h7FFF_FFFF);
		write_reg(CFG_AMOUNT, 32'h3_0000);
		rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h10000, 3, 4, 0,
			0, 0, 0, 0));
		rows.push_back(mk(32'h7FF0_0000, 32'h8010_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 9, 0,
			0, 0, 0, 0));
		rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 0, 1, 1, 1, 1, 1, 1, 1, 0));
		foreach (rows[i]) send(rows[i].p, rows[i].known, rows[i].r);
		drain();

		// random phases over settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_CENTER_X, $urandom_range(3) == 0 ? $urandom :
				32'($signed($urandom_range(2000000)) - 1000000));
			write_reg(CFG_CENTER_Y, $urandom_range(3) == 0 ? $urandom :
				32'($signed($urandom_range(2000000)) - 1000000));
			write_reg(CFG_CENTER_Z, $urandom_range(3) == 0 ? $urandom :
				32'($signed($urandom_range(2000000)) - 1000000));
			write_reg(CFG_RADIUS, ph == 1 ? 32'd16384 : ph == 2 ? 32'd6553600 :
				($urandom_range(4) == 0 ? $urandom : $urandom_range(6553600, 16384)));
			write_reg(CFG_AMOUNT, ph == 3 ? 32'd0 : ph == 4 ? 32'd1048576 : $urandom);
			write_reg(CFG_HEAT_MODE, $urandom);
			write_reg(CFG_PLANAR_MODE, $urandom);
			quiet = (ph == 5);
			for (int i = 0; i < N_RANDOM / 10; i++) begin
				send(rand_pcl(), 0, none);
				// sender waits out every result once
				if (ph == 6 && i == 50) begin
					pcl_valid <= 1'b0;
					while (scaled_q.size() != 0) @(posedge clk);
				end
			end
			quiet = 0;
			drain();
		end

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
